### design/selective_ack_receive_window_assert.svh
// Assertion macros for the selective acknowledgement receive window.
// Used by the top level; depends on signals named clock and reset in scope.
`ifndef SELECTIVE_ACK_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_ACK_RECEIVE_WINDOW_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAW_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("receive window check failed");
`define SAW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("receive window sequencing check failed");
`else
`define SAW_ASSERT(lbl, ante, cons)
`define SAW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/sackw_pkg.sv
// Shared types and constants of the selective acknowledgement receive window.
// Used by every module of the block; depends on nothing.
package sackw_pkg;

   localparam int MAX_WINDOW = 4096;
   localparam int SACK_BITS  = 64;

   localparam int PSN_W      = 24;
   localparam int BYTES_W    = 16;
   localparam int PROBE_W    = 16;
   localparam int TS_W       = 16;
   localparam int KIND_W     = 2;
   localparam int OFFSET_W   = 16;
   localparam int OOO_W      = 15;
   localparam int UNITS_W    = 24;
   localparam int BYTE_W     = 40;

   localparam int RING_IDX_W = $clog2(MAX_WINDOW);
   localparam int OFS_W      = $clog2(SACK_BITS);
   localparam int RING_ROWS  = MAX_WINDOW / SACK_BITS;
   localparam int ROW_W      = $clog2(RING_ROWS);
   localparam int RUN_W      = OFS_W + 1;
   localparam int HELD_W     = RING_IDX_W + 1;
   localparam int WIN_W      = 13;

   localparam logic [PSN_W-1:0] PSN_MAX = {PSN_W{1'b1}};
   localparam int HDR_BYTES  = 40;
   localparam int UNIT_BYTES = 256;
   localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
   localparam int OFS_MAX    = 32767;
   localparam int OFS_MIN    = -32768;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_LENGTH = 2'd0;
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(MAX_WINDOW);

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_PROBE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NACK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PROBE = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic [PSN_W-1:0]   psn;
      logic [BYTES_W-1:0] payload_bytes;
      logic [PROBE_W-1:0] probe_id;
      logic [TS_W-1:0]    timestamp;
      logic               congestion;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic [PSN_W-1:0]           cumulative_ack;
      logic signed [OFFSET_W-1:0] ack_offset;
      logic [SACK_BITS-1:0]       sack_bitmap;
      logic [OOO_W-1:0]           out_of_order_count;
      logic [UNITS_W-1:0]         received_units;
      logic [TS_W-1:0]            echo_timestamp;
      logic                       congestion_mark;
      logic [PSN_W-1:0]           reported_psn;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [ROW_W-1:0]     waddr;
      logic [SACK_BITS-1:0] wdata;
      logic                 rd_a_en;
      logic [ROW_W-1:0]     rd_a_addr;
      logic                 rd_b_en;
      logic [ROW_W-1:0]     rd_b_addr;
   } ring_req_type;

endpackage

### design/sackw_ring.sv
// Ring of held marks stored as wide words, one write and two registered reads.
// A row never written reads as zero through its valid bit. Depends on sackw_pkg.
module sackw_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  sackw_pkg::ring_req_type        ring_req,
   output logic [sackw_pkg::SACK_BITS-1:0] rd_a,
   output logic [sackw_pkg::SACK_BITS-1:0] rd_b
);
   import sackw_pkg::*;

   logic [SACK_BITS-1:0] mem [RING_ROWS];
   logic [RING_ROWS-1:0] row_valid_ff;
   logic [RING_ROWS-1:0] row_valid_in;
   logic [SACK_BITS-1:0] rd_a_ff;
   logic [SACK_BITS-1:0] rd_b_ff;
   logic                 rd_a_vld_ff;
   logic                 rd_b_vld_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ring_req.we) begin
         row_valid_in[ring_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_req.we) begin
         mem[ring_req.waddr] <= ring_req.wdata;
      end
      if (ring_req.rd_a_en) begin
         rd_a_ff     <= mem[ring_req.rd_a_addr];
         rd_a_vld_ff <= row_valid_ff[ring_req.rd_a_addr];
      end
      if (ring_req.rd_b_en) begin
         rd_b_ff     <= mem[ring_req.rd_b_addr];
         rd_b_vld_ff <= row_valid_ff[ring_req.rd_b_addr];
      end
   end

   assign rd_a = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b = rd_b_vld_ff ? rd_b_ff : '0;

endmodule

### design/sackw_scan.sv
// Shared scan unit: funnel shift of two ring words and run of ones from bit zero.
// Serves both the ack advance and the bitmap. Depends on sackw_pkg.
module sackw_scan (
   input  logic [sackw_pkg::SACK_BITS-1:0] lo,
   input  logic [sackw_pkg::SACK_BITS-1:0] hi,
   input  logic [sackw_pkg::OFS_W-1:0]     ofs,
   output logic [sackw_pkg::SACK_BITS-1:0] win,
   output logic [sackw_pkg::RUN_W-1:0]     run
);
   import sackw_pkg::*;

   function automatic logic [SACK_BITS-1:0] bit_mask(input int k);
      logic [SACK_BITS-1:0] m;
      m = '0;
      for (int j = 0; j < SACK_BITS; j++) begin
         m[j] = ((j >> k) & 1) != 0;
      end
      return m;
   endfunction

   logic [2*SACK_BITS-1:0] cat;
   logic [SACK_BITS-1:0]   zeros;
   logic [SACK_BITS-1:0]   lowest;
   logic [OFS_W-1:0]       idx;

   assign cat    = {hi, lo} >> ofs;
   assign win    = cat[SACK_BITS-1:0];
   assign zeros  = ~win;
   assign lowest = zeros & (~zeros + SACK_BITS'(1));

   always_comb begin
      for (int k = 0; k < OFS_W; k++) begin
         idx[k] = |(lowest & bit_mask(k));
      end
   end

   assign run = (zeros == '0) ? RUN_W'(SACK_BITS) : {1'b0, idx};

endmodule

### design/sackw_csr.sv
// Register port of the receive window: holds the window length register.
// APB-style access with no wait states. Depends on sackw_pkg.
module sackw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sackw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sackw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sackw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic [sackw_pkg::WIN_W-1:0]      window_length
);
   import sackw_pkg::*;

   logic [WIN_W-1:0] window_ff;
   logic [WIN_W-1:0] window_in;
   logic             wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      window_in = window_ff;
      if (wr_en && csr_paddr == ADDR_WINDOW_LENGTH) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(window_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign window_length = window_ff;

endmodule

### design/selective_ack_receive_window.sv
// Selective acknowledgement receive window for one flow. One request is worked on at a
// time and each gives exactly one response. A data request whose PSN lies above the
// cumulative ack goes from idle through mark and map read to map, with the response
// registered as map ends; a probe or a PSN at or below the cumulative ack skips mark,
// and an out-of-range NACK goes from idle straight to map. When a new PSN lets the
// cumulative ack advance, an advance read and an advance state come in for each 64-bit
// ring word the advance walks, since the ring is read, scanned and written back one word
// at a time through a single shared scan unit. A response waiting on rsp_stall holds the
// sequencer. The ring keeps one valid bit per word, so no clearing pass follows reset.
// Depends on sackw_pkg, sackw_ring, sackw_scan, sackw_csr and the assertion header.
`include "selective_ack_receive_window_assert.svh"
module selective_ack_receive_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sackw_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sackw_pkg::rsp_type               rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sackw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sackw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sackw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import sackw_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MARK, S_ADV_RD, S_ADV, S_MAP_RD, S_MAP} state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [PSN_W-1:0]     ack_ff, ack_in;
   logic [HELD_W-1:0]    held_ff, held_in;
   logic [BYTE_W-1:0]    bytes_ff, bytes_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   ring_req_type         ring_req;
   logic [SACK_BITS-1:0] ring_rd_a;
   logic [SACK_BITS-1:0] ring_rd_b;
   logic [WIN_W-1:0]     window_length;

   logic [SACK_BITS-1:0] scan_hi;
   logic [SACK_BITS-1:0] scan_win;
   logic [RUN_W-1:0]     scan_run;

   logic [PSN_W:0]       ack_plus1;
   logic [ROW_W-1:0]     cur_row;
   logic [OFS_W-1:0]     cur_ofs;
   logic [WIN_W-1:0]     win_eff;
   logic [PSN_W:0]       limit;
   logic                 is_nack;
   logic [ROW_W-1:0]     psn_row;
   logic [OFS_W-1:0]     psn_ofs;
   logic                 mark_bit;
   logic                 psn_is_next;
   logic [SACK_BITS-1:0] run_mask;
   logic                 run_end;
   logic [PSN_W-1:0]     ack_adv;
   logic [BYTE_W:0]      byte_sum;
   logic [BYTE_W-1:0]    byte_sat;
   logic [BYTE_W:0]      byte_rnd;
   logic [BYTE_W-UNIT_SHIFT:0] units_full;
   logic [UNITS_W-1:0]   units;
   logic signed [PSN_W+1:0] diff;
   logic [OFFSET_W-1:0]  sack_ofs;
   logic [OFFSET_W-1:0]  probe_ofs;
   logic [SACK_BITS-1:0] bitmap;
   logic                 out_free;
   rsp_type              rsp_build;

   sackw_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .window_length (window_length)
   );

   sackw_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_req (ring_req),
      .rd_a     (ring_rd_a),
      .rd_b     (ring_rd_b)
   );

   sackw_scan u_scan (
      .lo  (ring_rd_a),
      .hi  (scan_hi),
      .ofs (cur_ofs),
      .win (scan_win),
      .run (scan_run)
   );

   assign ack_plus1 = {1'b0, ack_ff} + (PSN_W+1)'(1);
   assign cur_row   = ack_plus1[RING_IDX_W-1:OFS_W];
   assign cur_ofs   = ack_plus1[OFS_W-1:0];

   assign win_eff = (window_length > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_length;
   assign limit   = {1'b0, ack_ff} + (PSN_W+1)'(win_eff);
   assign is_nack = {1'b0, req_data.psn} > limit;

   assign psn_row     = req_ff.psn[RING_IDX_W-1:OFS_W];
   assign psn_ofs     = req_ff.psn[OFS_W-1:0];
   assign mark_bit    = ring_rd_a[psn_ofs];
   assign psn_is_next = ({1'b0, req_ff.psn} == ack_plus1);

   // The word above the last PSN of the sequence space holds nothing.
   assign scan_hi = (state_ff == S_MAP && !(&ack_plus1[PSN_W-1:OFS_W])) ? ring_rd_b : '0;

   assign run_mask = ((SACK_BITS'(1) << scan_run) - SACK_BITS'(1)) << cur_ofs;
   assign run_end  = (RUN_W'(cur_ofs) + scan_run) == RUN_W'(SACK_BITS);
   assign ack_adv  = ack_ff + PSN_W'(scan_run);

   assign byte_sum = {1'b0, bytes_ff} + (BYTE_W+1)'(req_ff.payload_bytes)
                     + (BYTE_W+1)'(HDR_BYTES);
   assign byte_sat = byte_sum[BYTE_W] ? {BYTE_W{1'b1}} : byte_sum[BYTE_W-1:0];

   assign byte_rnd   = {1'b0, bytes_ff} + (BYTE_W+1)'(UNIT_BYTES - 1);
   assign units_full = byte_rnd[BYTE_W:UNIT_SHIFT];
   assign units      = (units_full > (BYTE_W-UNIT_SHIFT+1)'(PSN_MAX)) ? UNITS_W'(PSN_MAX)
                                                                        : units_full[UNITS_W-1:0];

   assign diff = $signed({2'b00, req_ff.psn}) - $signed({2'b00, ack_ff});
   always_comb begin
      if (diff < $signed((PSN_W+2)'(OFS_MIN))) begin
         sack_ofs = OFFSET_W'(OFS_MIN);
      end else if (diff > $signed((PSN_W+2)'(OFS_MAX))) begin
         sack_ofs = OFFSET_W'(OFS_MAX);
      end else begin
         sack_ofs = diff[OFFSET_W-1:0];
      end
   end
   assign probe_ofs = req_ff.probe_id[PROBE_W-1] ? OFFSET_W'(OFS_MAX) : req_ff.probe_id;

   assign bitmap = ack_plus1[PSN_W] ? '0 : scan_win;

   always_comb begin
      rsp_build.kind               = kind_ff;
      rsp_build.cumulative_ack     = ack_ff;
      rsp_build.ack_offset         = (kind_ff == KIND_PROBE) ? probe_ofs : sack_ofs;
      rsp_build.sack_bitmap        = bitmap;
      rsp_build.out_of_order_count = OOO_W'(held_ff);
      rsp_build.received_units     = units;
      rsp_build.echo_timestamp     = req_ff.timestamp;
      rsp_build.congestion_mark    = req_ff.congestion;
      rsp_build.reported_psn       = ack_ff;
      if (kind_ff == KIND_NACK) begin
         rsp_build.ack_offset         = '0;
         rsp_build.sack_bitmap        = '0;
         rsp_build.out_of_order_count = '0;
         rsp_build.received_units     = '0;
         rsp_build.congestion_mark    = 1'b0;
         rsp_build.reported_psn       = req_ff.psn;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      kind_in      = kind_ff;
      ack_in       = ack_ff;
      held_in      = held_ff;
      bytes_in     = bytes_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ring_req     = '0;
      unique case (state_ff)
         S_IDLE: begin
            ring_req.rd_a_en   = req_valid;
            ring_req.rd_a_addr = req_data.psn[RING_IDX_W-1:OFS_W];
            if (req_valid) begin
               req_in = req_data;
               if (req_data.cmd == CMD_PROBE) begin
                  kind_in  = KIND_PROBE;
                  state_in = S_MAP_RD;
               end else if (is_nack) begin
                  kind_in  = KIND_NACK;
                  state_in = S_MAP;
               end else if (req_data.psn > ack_ff) begin
                  kind_in  = KIND_SACK;
                  state_in = S_MARK;
               end else begin
                  kind_in  = KIND_SACK;
                  state_in = S_MAP_RD;
               end
            end
         end
         S_MARK: begin
            if (!mark_bit) begin
               ring_req.we    = 1'b1;
               ring_req.waddr = psn_row;
               ring_req.wdata = ring_rd_a | (SACK_BITS'(1) << psn_ofs);
               held_in        = held_ff + HELD_W'(1);
               bytes_in       = byte_sat;
            end
            state_in = (!mark_bit && psn_is_next) ? S_ADV_RD : S_MAP_RD;
         end
         S_ADV_RD: begin
            ring_req.rd_a_en   = 1'b1;
            ring_req.rd_a_addr = cur_row;
            state_in           = S_ADV;
         end
         S_ADV: begin
            ring_req.we    = 1'b1;
            ring_req.waddr = cur_row;
            ring_req.wdata = ring_rd_a & ~run_mask;
            ack_in         = ack_adv;
            held_in        = held_ff - HELD_W'(scan_run);
            state_in       = (run_end && ack_adv != PSN_MAX) ? S_ADV_RD : S_MAP_RD;
         end
         S_MAP_RD: begin
            ring_req.rd_a_en   = 1'b1;
            ring_req.rd_a_addr = cur_row;
            ring_req.rd_b_en   = 1'b1;
            ring_req.rd_b_addr = cur_row + ROW_W'(1);
            state_in           = S_MAP;
         end
         S_MAP: begin
            if (out_free) begin
               rsp_in       = rsp_build;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ack_ff       <= '0;
         held_ff      <= '0;
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ack_ff       <= ack_in;
         held_ff      <= held_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      kind_ff <= kind_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SAW_ASSERT_NXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != S_IDLE)
   `SAW_ASSERT(a_rsp_from_map, $rose(rsp_valid_ff), $past(state_ff) == S_MAP)
   `SAW_ASSERT(a_held_bound, 1'b1, held_ff <= HELD_W'(MAX_WINDOW))
   `SAW_ASSERT(a_ack_monotonic, !$past(reset), ack_ff >= $past(ack_ff))

endmodule
